/* sv/complex_arith_unit_defines.svh */
// Assertion macros shared by the checker of the complex arithmetic unit.
`ifndef COMPLEX_ARITH_UNIT_DEFINES_SVH
`define COMPLEX_ARITH_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CAU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("complex_arith_unit: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CAU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("complex_arith_unit: check failed");

`endif

/* sv/cau_pkg.sv */
`default_nettype none
package cau_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4
    } op_t;

    // Control flags that travel alongside each word down the pipeline.
    typedef struct packed {
        logic valid;
        op_t  op;
        logic is_eq;
        logic dz;
        logic a_r_neg;
        logic a_i_neg;
        logic n_r_neg;
        logic n_i_neg;
    } ctrl_t;

endpackage
`default_nettype wire

/* sv/cau_front.sv */
`default_nettype none
module cau_front #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic [2:0]                           req_type,
    input  logic signed [WORD_BITS-1:0]          a_real,
    input  logic signed [WORD_BITS-1:0]          a_imag,
    input  logic signed [WORD_BITS-1:0]          b_real,
    input  logic signed [WORD_BITS-1:0]          b_imag,
    output cau_pkg::ctrl_t                       ctrl,
    output logic signed [2*WORD_BITS-FRAC_BITS:0] val_r,
    output logic signed [2*WORD_BITS-FRAC_BITS:0] val_i,
    output logic [2*WORD_BITS:0]                 mag_r,
    output logic [2*WORD_BITS:0]                 mag_i,
    output logic [2*WORD_BITS-1:0]               den
);

    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int VAL_BITS  = 2 * WORD_BITS - FRAC_BITS + 1;

    cau_pkg::ctrl_t ctrl_a_reg, ctrl_a_next;
    cau_pkg::ctrl_t ctrl_b_reg, ctrl_b_next;
    cau_pkg::ctrl_t ctrl_c_reg, ctrl_c_next;

    logic signed [WORD_BITS-1:0] ar_reg, ai_reg, br_reg, bi_reg;

    logic signed [PROD_BITS-1:0] p_rr_reg, p_ii_reg, p_ir_reg, p_ri_reg, p_bb_reg, p_cc_reg;
    logic signed [PROD_BITS-1:0] p_rr_next, p_ii_next, p_ir_next, p_ri_next;
    logic signed [PROD_BITS-1:0] p_bb_next, p_cc_next;
    logic signed [WORD_BITS:0]   lin_r_reg, lin_i_reg, lin_r_next, lin_i_next;

    logic signed [PROD_BITS:0]   mul_r, mul_i, num_r, num_i;
    logic signed [VAL_BITS-1:0]  val_r_reg, val_i_reg, val_r_next, val_i_next;
    logic [PROD_BITS:0]          mag_r_reg, mag_i_reg, mag_r_next, mag_i_next;
    logic [PROD_BITS-1:0]        den_reg, den_next;

    always_comb
    begin
        ctrl_a_next       = '0;
        ctrl_a_next.valid = in_valid;
        ctrl_a_next.op    = cau_pkg::op_t'(req_type);
    end

    // Stage B: the six partial products and the linear results.
    always_comb
    begin
        p_rr_next = ar_reg * br_reg;
        p_ii_next = ai_reg * bi_reg;
        p_ir_next = ai_reg * br_reg;
        p_ri_next = ar_reg * bi_reg;
        p_bb_next = br_reg * br_reg;
        p_cc_next = bi_reg * bi_reg;

        ctrl_b_next         = ctrl_a_reg;
        ctrl_b_next.is_eq   = (ctrl_a_reg.op == cau_pkg::OP_CMP) &&
                              (ar_reg == br_reg) && (ai_reg == bi_reg);
        ctrl_b_next.dz      = (ctrl_a_reg.op == cau_pkg::OP_DIV) &&
                              (br_reg == '0) && (bi_reg == '0);
        ctrl_b_next.a_r_neg = ar_reg[WORD_BITS-1];
        ctrl_b_next.a_i_neg = ai_reg[WORD_BITS-1];

        if (ctrl_a_reg.op == cau_pkg::OP_SUB)
        begin
            lin_r_next = (WORD_BITS+1)'(ar_reg) - (WORD_BITS+1)'(br_reg);
            lin_i_next = (WORD_BITS+1)'(ai_reg) - (WORD_BITS+1)'(bi_reg);
        end
        else
        begin
            lin_r_next = (WORD_BITS+1)'(ar_reg) + (WORD_BITS+1)'(br_reg);
            lin_i_next = (WORD_BITS+1)'(ai_reg) + (WORD_BITS+1)'(bi_reg);
        end
    end

    // Stage C: combine products, form divide magnitudes and the divisor.
    always_comb
    begin
        mul_r = (PROD_BITS+1)'(p_rr_reg) - (PROD_BITS+1)'(p_ii_reg);
        mul_i = (PROD_BITS+1)'(p_ir_reg) + (PROD_BITS+1)'(p_ri_reg);
        num_r = (PROD_BITS+1)'(p_rr_reg) + (PROD_BITS+1)'(p_ii_reg);
        num_i = (PROD_BITS+1)'(p_ir_reg) - (PROD_BITS+1)'(p_ri_reg);

        ctrl_c_next         = ctrl_b_reg;
        ctrl_c_next.n_r_neg = num_r[PROD_BITS];
        ctrl_c_next.n_i_neg = num_i[PROD_BITS];

        mag_r_next = num_r[PROD_BITS] ? -num_r : num_r;
        mag_i_next = num_i[PROD_BITS] ? -num_i : num_i;
        den_next   = p_bb_reg + p_cc_reg;

        if (ctrl_b_reg.op == cau_pkg::OP_MUL)
        begin
            // Arithmetic shift right by the fraction width floors the product.
            val_r_next = mul_r[PROD_BITS:FRAC_BITS];
            val_i_next = mul_i[PROD_BITS:FRAC_BITS];
        end
        else
        begin
            val_r_next = VAL_BITS'(lin_r_reg);
            val_i_next = VAL_BITS'(lin_i_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_a_reg <= '0;
            ctrl_b_reg <= '0;
            ctrl_c_reg <= '0;
        end
        else
        begin
            ctrl_a_reg <= ctrl_a_next;
            ctrl_b_reg <= ctrl_b_next;
            ctrl_c_reg <= ctrl_c_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ar_reg    <= a_real;
        ai_reg    <= a_imag;
        br_reg    <= b_real;
        bi_reg    <= b_imag;
        p_rr_reg  <= p_rr_next;
        p_ii_reg  <= p_ii_next;
        p_ir_reg  <= p_ir_next;
        p_ri_reg  <= p_ri_next;
        p_bb_reg  <= p_bb_next;
        p_cc_reg  <= p_cc_next;
        lin_r_reg <= lin_r_next;
        lin_i_reg <= lin_i_next;
        val_r_reg <= val_r_next;
        val_i_reg <= val_i_next;
        mag_r_reg <= mag_r_next;
        mag_i_reg <= mag_i_next;
        den_reg   <= den_next;
    end

    assign ctrl  = ctrl_c_reg;
    assign val_r = val_r_reg;
    assign val_i = val_i_reg;
    assign mag_r = mag_r_reg;
    assign mag_i = mag_i_reg;
    assign den   = den_reg;

endmodule
`default_nettype wire

/* sv/cau_div_stage.sv */
`default_nettype none
module cau_div_stage #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  cau_pkg::ctrl_t                             in_ctrl,
    input  logic [2*WORD_BITS-1:0]                     in_den,
    input  logic signed [2*WORD_BITS-FRAC_BITS:0]      in_val_r,
    input  logic signed [2*WORD_BITS-FRAC_BITS:0]      in_val_i,
    input  logic [1:0][2*WORD_BITS-1:0]                in_rem,
    input  logic [1:0][2*WORD_BITS+FRAC_BITS:0]        in_dvd,
    input  logic [1:0][WORD_BITS:0]                    in_q,
    input  logic [1:0]                                 in_sticky,
    output cau_pkg::ctrl_t                             out_ctrl,
    output logic [2*WORD_BITS-1:0]                     out_den,
    output logic signed [2*WORD_BITS-FRAC_BITS:0]      out_val_r,
    output logic signed [2*WORD_BITS-FRAC_BITS:0]      out_val_i,
    output logic [1:0][2*WORD_BITS-1:0]                out_rem,
    output logic [1:0][2*WORD_BITS+FRAC_BITS:0]        out_dvd,
    output logic [1:0][WORD_BITS:0]                    out_q,
    output logic [1:0]                                 out_sticky
);

    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int DVD_BITS  = 2 * WORD_BITS + FRAC_BITS + 1;
    localparam int VAL_BITS  = 2 * WORD_BITS - FRAC_BITS + 1;

    cau_pkg::ctrl_t              ctrl_reg;
    logic [PROD_BITS-1:0]        den_reg;
    logic signed [VAL_BITS-1:0]  val_r_reg, val_i_reg;
    logic [1:0][PROD_BITS-1:0]   rem_reg, rem_next;
    logic [1:0][DVD_BITS-1:0]    dvd_reg, dvd_next;
    logic [1:0][WORD_BITS:0]     q_reg, q_next;
    logic [1:0]                  sticky_reg, sticky_next;

    // One restoring-division step per lane: bring down a dividend bit,
    // subtract the divisor when it fits, shift the quotient bit in.
    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic [PROD_BITS:0] trial;
        logic [PROD_BITS:0] diff;
        logic               fits;

        always_comb
        begin
            trial          = {in_rem[l], in_dvd[l][DVD_BITS-1]};
            diff           = trial - {1'b0, in_den};
            fits           = (trial >= {1'b0, in_den});
            rem_next[l]    = fits ? diff[PROD_BITS-1:0] : trial[PROD_BITS-1:0];
            dvd_next[l]    = {in_dvd[l][DVD_BITS-2:0], 1'b0};
            q_next[l]      = {in_q[l][WORD_BITS-1:0], fits};
            // Any quotient bit pushed past the kept window means saturation.
            sticky_next[l] = in_sticky[l] | in_q[l][WORD_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge clk)
    begin
        den_reg    <= in_den;
        val_r_reg  <= in_val_r;
        val_i_reg  <= in_val_i;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        q_reg      <= q_next;
        sticky_reg <= sticky_next;
    end

    assign out_ctrl   = ctrl_reg;
    assign out_den    = den_reg;
    assign out_val_r  = val_r_reg;
    assign out_val_i  = val_i_reg;
    assign out_rem    = rem_reg;
    assign out_dvd    = dvd_reg;
    assign out_q      = q_reg;
    assign out_sticky = sticky_reg;

endmodule
`default_nettype wire

/* sv/cau_out_stage.sv */
`default_nettype none
module cau_out_stage #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  cau_pkg::ctrl_t                        in_ctrl,
    input  logic signed [2*WORD_BITS-FRAC_BITS:0] in_val_r,
    input  logic signed [2*WORD_BITS-FRAC_BITS:0] in_val_i,
    input  logic [1:0][WORD_BITS:0]               in_q,
    input  logic [1:0]                            in_sticky,
    output logic                                  done,
    output logic signed [WORD_BITS-1:0]           res_real,
    output logic signed [WORD_BITS-1:0]           res_imag,
    output logic                                  is_equal,
    output logic                                  divide_by_zero,
    output logic                                  overflowed
);

    localparam int VAL_BITS = 2 * WORD_BITS - FRAC_BITS + 1;
    localparam logic [WORD_BITS-1:0] SAT_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] SAT_MIN = ~SAT_MAX;

    logic [1:0][WORD_BITS-1:0] lin_res, div_res, zero_res;
    logic [1:0]                lin_ovf, div_ovf;

    logic                 done_reg, done_next;
    logic [WORD_BITS-1:0] res_real_reg, res_real_next, res_imag_reg, res_imag_next;
    logic                 eq_reg, eq_next, dz_reg, dz_next, ovf_reg, ovf_next;

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic [VAL_BITS-1:0]         val;
        logic [VAL_BITS-WORD_BITS:0] top_bits;
        logic [WORD_BITS-1:0]        q_low;
        logic                        q_neg;
        logic                        q_big;

        always_comb
        begin
            val      = (l == 0) ? in_val_r : in_val_i;
            // The value fits when every bit from the word's sign bit up agrees.
            top_bits = val[VAL_BITS-1:WORD_BITS-1];
            lin_ovf[l] = !((&top_bits) || (~|top_bits));
            lin_res[l] = lin_ovf[l] ? (val[VAL_BITS-1] ? SAT_MIN : SAT_MAX)
                                    : val[WORD_BITS-1:0];

            q_low = in_q[l][WORD_BITS-1:0];
            q_neg = (l == 0) ? in_ctrl.n_r_neg : in_ctrl.n_i_neg;
            q_big = in_sticky[l] | in_q[l][WORD_BITS];
            div_ovf[l] = q_big || (q_neg ? (q_low[WORD_BITS-1] && (|q_low[WORD_BITS-2:0]))
                                         : q_low[WORD_BITS-1]);
            div_res[l] = div_ovf[l] ? (q_neg ? SAT_MIN : SAT_MAX)
                                    : (q_neg ? (~q_low + 1'b1) : q_low);

            zero_res[l] = ((l == 0) ? in_ctrl.a_r_neg : in_ctrl.a_i_neg) ? SAT_MIN : SAT_MAX;
        end
    end

    always_comb
    begin
        done_next     = in_ctrl.valid;
        res_real_next = '0;
        res_imag_next = '0;
        eq_next       = 1'b0;
        dz_next       = 1'b0;
        ovf_next      = 1'b0;
        case (in_ctrl.op)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL:
            begin
                res_real_next = lin_res[0];
                res_imag_next = lin_res[1];
                ovf_next      = |lin_ovf;
            end
            cau_pkg::OP_DIV:
            begin
                if (in_ctrl.dz)
                begin
                    res_real_next = zero_res[0];
                    res_imag_next = zero_res[1];
                    dz_next       = 1'b1;
                end
                else
                begin
                    res_real_next = div_res[0];
                    res_imag_next = div_res[1];
                    ovf_next      = |div_ovf;
                end
            end
            cau_pkg::OP_CMP:
            begin
                eq_next = in_ctrl.is_eq;
            end
            default:
            begin
                eq_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_real_reg <= res_real_next;
        res_imag_reg <= res_imag_next;
        eq_reg       <= eq_next;
        dz_reg       <= dz_next;
        ovf_reg      <= ovf_next;
    end

    assign done           = done_reg;
    assign res_real       = res_real_reg;
    assign res_imag       = res_imag_reg;
    assign is_equal       = eq_reg;
    assign divide_by_zero = dz_reg;
    assign overflowed     = ovf_reg;

endmodule
`default_nettype wire

/* sv/complex_arith_unit.sv */
`default_nettype none
// Complex fixed-point ALU on signed operands with FRAC_BITS fraction bits.
// Input: a word is taken at a rising edge where start is high and busy is
// low. busy is always low, so a new word may be issued in every cycle.
// req_type selects add, subtract, multiply, divide or exact compare.
// Output: each word yields one result, shown for one cycle with done high.
// done rises once the word has passed front stages A, B and C, every divider
// stage and the output register; results leave in order.
// The divider gives one quotient bit per pipeline stage, in
// 2*WORD_BITS+FRAC_BITS+1 stages, which every operation passes through.
// Throughput is one word per cycle for every operation mix.
// Results saturate and raise overflowed; a zero divisor raises
// divide_by_zero and gives saturated parts following the signs of a.
// The receiver cannot hold results off; nothing in the pipe ever stalls.
// Reset clears every valid bit, so no result appears for words in flight.
module complex_arith_unit #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  req_type,
    input  logic signed [WORD_BITS-1:0] a_real,
    input  logic signed [WORD_BITS-1:0] a_imag,
    input  logic signed [WORD_BITS-1:0] b_real,
    input  logic signed [WORD_BITS-1:0] b_imag,
    output logic                        done,
    output logic signed [WORD_BITS-1:0] res_real,
    output logic signed [WORD_BITS-1:0] res_imag,
    output logic                        is_equal,
    output logic                        divide_by_zero,
    output logic                        overflowed
);

    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int DVD_BITS  = 2 * WORD_BITS + FRAC_BITS + 1;
    localparam int VAL_BITS  = 2 * WORD_BITS - FRAC_BITS + 1;
    localparam int DIV_STEPS = DVD_BITS;

    cau_pkg::ctrl_t             ctrl_s   [0:DIV_STEPS];
    logic [PROD_BITS-1:0]       den_s    [0:DIV_STEPS];
    logic signed [VAL_BITS-1:0] val_r_s  [0:DIV_STEPS];
    logic signed [VAL_BITS-1:0] val_i_s  [0:DIV_STEPS];
    logic [1:0][PROD_BITS-1:0]  rem_s    [0:DIV_STEPS];
    logic [1:0][DVD_BITS-1:0]   dvd_s    [0:DIV_STEPS];
    logic [1:0][WORD_BITS:0]    q_s      [0:DIV_STEPS];
    logic [1:0]                 sticky_s [0:DIV_STEPS];
    logic [PROD_BITS:0]         mag_r, mag_i;

    assign busy = 1'b0;

    cau_front #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .req_type (req_type),
        .a_real   (a_real),
        .a_imag   (a_imag),
        .b_real   (b_real),
        .b_imag   (b_imag),
        .ctrl     (ctrl_s[0]),
        .val_r    (val_r_s[0]),
        .val_i    (val_i_s[0]),
        .mag_r    (mag_r),
        .mag_i    (mag_i),
        .den      (den_s[0])
    );

    // The dividend is the numerator magnitude scaled by the fraction width.
    assign dvd_s[0][0]  = {mag_r, {FRAC_BITS{1'b0}}};
    assign dvd_s[0][1]  = {mag_i, {FRAC_BITS{1'b0}}};
    assign rem_s[0]     = '0;
    assign q_s[0]       = '0;
    assign sticky_s[0]  = '0;

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_div
        cau_div_stage #(
            .WORD_BITS (WORD_BITS),
            .FRAC_BITS (FRAC_BITS)
        ) u_stage (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_ctrl    (ctrl_s[s]),
            .in_den     (den_s[s]),
            .in_val_r   (val_r_s[s]),
            .in_val_i   (val_i_s[s]),
            .in_rem     (rem_s[s]),
            .in_dvd     (dvd_s[s]),
            .in_q       (q_s[s]),
            .in_sticky  (sticky_s[s]),
            .out_ctrl   (ctrl_s[s+1]),
            .out_den    (den_s[s+1]),
            .out_val_r  (val_r_s[s+1]),
            .out_val_i  (val_i_s[s+1]),
            .out_rem    (rem_s[s+1]),
            .out_dvd    (dvd_s[s+1]),
            .out_q      (q_s[s+1]),
            .out_sticky (sticky_s[s+1])
        );
    end

    cau_out_stage #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ctrl        (ctrl_s[DIV_STEPS]),
        .in_val_r       (val_r_s[DIV_STEPS]),
        .in_val_i       (val_i_s[DIV_STEPS]),
        .in_q           (q_s[DIV_STEPS]),
        .in_sticky      (sticky_s[DIV_STEPS]),
        .done           (done),
        .res_real       (res_real),
        .res_imag       (res_imag),
        .is_equal       (is_equal),
        .divide_by_zero (divide_by_zero),
        .overflowed     (overflowed)
    );

endmodule
`default_nettype wire

/* sv/cau_checker.sv */
`default_nettype none
`include "complex_arith_unit_defines.svh"
module cau_checker #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        busy,
    input logic                        done,
    input logic signed [WORD_BITS-1:0] res_real,
    input logic signed [WORD_BITS-1:0] res_imag,
    input logic                        is_equal,
    input logic                        divide_by_zero,
    input logic                        overflowed
);

    localparam logic [WORD_BITS-1:0] SAT_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic [WORD_BITS-1:0] SAT_MIN = ~SAT_MAX;

    logic res_zero;
    logic re_sat;
    logic im_sat;

    assign res_zero = (res_real == '0) && (res_imag == '0);
    assign re_sat   = (res_real == SAT_MAX) || (res_real == SAT_MIN);
    assign im_sat   = (res_imag == SAT_MAX) || (res_imag == SAT_MIN);

    // The pipeline never pushes back on the issuer.
    `CAU_ASSERT_NXT(a_never_busy, 1'b1, !busy)

    `CAU_ASSERT_IMP(a_dz_flags, done && divide_by_zero, !overflowed && !is_equal)

    `CAU_ASSERT_IMP(a_eq_zero, done && is_equal, res_zero && !overflowed)

    `CAU_ASSERT_IMP(a_dz_sat, done && divide_by_zero, re_sat && im_sat)

endmodule

bind complex_arith_unit cau_checker #(.WORD_BITS(WORD_BITS)) u_cau_checker (.*);
`default_nettype wire

/* tb/sv/complex_arith_checker.sv */
`default_nettype none
module complex_arith_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [2:0]         req_type,
    input  logic signed [31:0] a_real,
    input  logic signed [31:0] a_imag,
    input  logic signed [31:0] b_real,
    input  logic signed [31:0] b_imag,
    input  logic               done,
    input  logic signed [31:0] res_real,
    input  logic signed [31:0] res_imag,
    input  logic               is_equal,
    input  logic               divide_by_zero,
    input  logic               overflowed,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        eq;
        logic        dz;
        logic        ovf;
    } answer_t;

    answer_t answers[$];

    localparam logic signed [31:0] WMAX = 32'sh7fffffff;
    localparam logic signed [31:0] WMIN = 32'sh80000000;

    assign pending = answers.size();

    // Clamp a wide value to one word and note whether it was clamped.
    function automatic logic [31:0] clamp(input logic signed [127:0] v, inout logic ovf);
        if (v > 128'(WMAX)) begin
            ovf = 1'b1;
            return WMAX;
        end
        if (v < 128'(signed'(WMIN))) begin
            ovf = 1'b1;
            return WMIN;
        end
        return v[31:0];
    endfunction

    // Numerator scaled by the fraction bits, then truncated toward zero.
    function automatic logic signed [127:0] scaled_quot(input logic signed [127:0] num,
                                                       input logic signed [127:0] den);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        mag = (num < 0) ? -num : num;
        q = (mag <<< 16) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic answer_t complex_result(input logic [2:0] op,
                                               input logic signed [31:0] ar, ai, br, bi);
        answer_t r;
        logic signed [127:0] xr, xi, yr, yi, den;
        r = '0;
        xr = ar; xi = ai; yr = br; yi = bi;
        case (op)
            cau_pkg::OP_ADD:
            begin
                r.re = clamp(xr + yr, r.ovf);
                r.im = clamp(xi + yi, r.ovf);
            end
            cau_pkg::OP_SUB:
            begin
                r.re = clamp(xr - yr, r.ovf);
                r.im = clamp(xi - yi, r.ovf);
            end
            cau_pkg::OP_MUL:
            begin
                r.re = clamp((xr * yr - xi * yi) >>> 16, r.ovf);
                r.im = clamp((yr * xi + xr * yi) >>> 16, r.ovf);
            end
            cau_pkg::OP_DIV:
            begin
                if (br == 0 && bi == 0)
                begin
                    r.dz = 1'b1;
                    r.re = (ar >= 0) ? WMAX : WMIN;
                    r.im = (ai >= 0) ? WMAX : WMIN;
                end
                else
                begin
                    den = yr * yr + yi * yi;
                    r.re = clamp(scaled_quot(xr * yr + xi * yi, den), r.ovf);
                    r.im = clamp(scaled_quot(xi * yr - xr * yi, den), r.ovf);
                end
            end
            cau_pkg::OP_CMP:
            begin
                r.eq = (ar == br && ai == bi);
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk)
    begin
        answer_t w;
        if (rst_n)
        begin
            if (done)
            begin
                if (answers.size() == 0)
                begin
                    report("unexpected result word", 32'(done), 32'h0);
                end
                else
                begin
                    w = answers.pop_front();
                    if (res_real !== w.re) report("res_real", res_real, w.re);
                    if (res_imag !== w.im) report("res_imag", res_imag, w.im);
                    if (is_equal !== w.eq) report("is_equal", is_equal, w.eq);
                    if (divide_by_zero !== w.dz)
                        report("divide_by_zero", divide_by_zero, w.dz);
                    if (overflowed !== w.ovf) report("overflowed", overflowed, w.ovf);
                end
            end
            if (start && !busy)
                answers.push_back(complex_result(req_type, a_real, a_imag, b_real, b_imag));
        end
    end

endmodule
`default_nettype wire

/* tb/sv/tb_complex_arith_unit.sv */
`default_nettype none
module tb_complex_arith_unit;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         req_type = '0;
    logic signed [31:0] a_real = '0;
    logic signed [31:0] a_imag = '0;
    logic signed [31:0] b_real = '0;
    logic signed [31:0] b_imag = '0;
    logic               done;
    logic signed [31:0] res_real;
    logic signed [31:0] res_imag;
    logic               is_equal;
    logic               divide_by_zero;
    logic               overflowed;
    int                 fail_count;
    int                 pending;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    complex_arith_unit dut (.*);
    complex_arith_checker checker_i (.*);

    // Operand part: mostly small values, sometimes extremes or full-range noise.
    function automatic logic [31:0] pick_part();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3, 4: return $urandom();
            5: return {{16{1'b0}}, 16'($urandom())} - 32'h8000;
            default: return 32'($signed($urandom_range(0, 2000000))) - 1000000;
        endcase
    endfunction

    task automatic send_word(input logic [2:0] op, input logic [31:0] ar, ai, br, bi);
        req_type <= op;
        a_real <= ar;
        a_imag <= ai;
        b_real <= br;
        b_imag <= bi;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic idle_maybe(input bit quiet);
        if (!quiet && $urandom_range(0, 99) < 13)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    initial
    begin
        logic [31:0] ar, ai;
        logic [2:0]  op;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_word(cau_pkg::OP_ADD, 32'h7fffffff, 32'h80000000, 32'h1, 32'hffffffff);
        send_word(cau_pkg::OP_ADD, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_word(cau_pkg::OP_SUB, 32'h80000000, 32'h7fffffff, 32'h1, 32'hffffffff);
        send_word(cau_pkg::OP_SUB, 32'h00010000, 32'h0, 32'h00008000, 32'h0);
        send_word(cau_pkg::OP_MUL, 32'h00020000, 32'h00030000, 32'h00040000, 32'hffff0000);
        send_word(cau_pkg::OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_word(cau_pkg::OP_MUL, 32'hffffffff, 32'h0, 32'h1, 32'h0);
        send_word(cau_pkg::OP_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        send_word(cau_pkg::OP_DIV, 32'h00010000, 32'h0, 32'h00020000, 32'h0);
        send_word(cau_pkg::OP_DIV, 32'h00050000, 32'hfffd0000, 32'h00010000, 32'h00020000);
        send_word(cau_pkg::OP_DIV, 32'h7fffffff, 32'h80000000, 32'h1, 32'h0);
        send_word(cau_pkg::OP_DIV, 32'hffffffff, 32'h1, 32'h0, 32'h00030000);
        send_word(cau_pkg::OP_DIV, 32'h0, 32'hffffffff, 32'h0, 32'h0);
        send_word(cau_pkg::OP_DIV, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0);
        send_word(cau_pkg::OP_CMP, 32'h12345678, 32'h9abcdef0, 32'h12345678, 32'h9abcdef0);
        send_word(cau_pkg::OP_CMP, 32'h12345678, 32'h9abcdef0, 32'h12345678, 32'h9abcdef1);
        send_word(cau_pkg::OP_CMP, 32'h0, 32'h1, 32'h1, 32'h1);
        send_word(3'd5, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_word(3'd6, 32'h1, 32'h2, 32'h3, 32'h4);
        send_word(3'd7, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0);

        // Hold off until the pipe has drained completely.
        start <= 1'b0;
        while (pending != 0) @(negedge clk);

        for (int n = 0; n < 1800; n++)
        begin
            idle_maybe(n >= 600 && n < 900);
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            ar = pick_part();
            ai = pick_part();
            if (op == cau_pkg::OP_CMP && $urandom_range(0, 1))
                send_word(op, ar, ai, ar, $urandom_range(0, 1) ? ai : ai ^ 32'h1);
            else if (op == cau_pkg::OP_DIV && $urandom_range(0, 9) == 0)
                send_word(op, ar, ai, 32'h0, 32'h0);
            else
                send_word(op, ar, ai, pick_part(), pick_part());
        end
        start <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0)
            $display("complex_arith_unit regression: pass");
        else
            $display("complex_arith_unit regression: fail");
        $finish;
    end

    initial
    begin
        #200000;
        $display("complex_arith_unit regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
